// File: src/assert_macros.svh
// Assertion macros used by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge, masked while reset is low
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/tbbh_pkg.sv
// Shared types, constants and command/status structs of the time-binned histogram
package tbbh_pkg;

    localparam int TS_W    = 48;
    localparam int BYTES_W = 16;
    localparam int RBIN_W  = 10;
    localparam int CFG_W   = 11;

    localparam int S_TDATA_W = ((TS_W + BYTES_W + RBIN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((TS_W + TS_W + 1 + 7) / 8) * 8;

    localparam int unsigned MAX_BINS_DEF  = 1024;
    localparam int unsigned BIN_WIDTH_DEF = 1000000;

    localparam logic [CFG_W-1:0] NUM_BINS_RST = CFG_W'(1024);

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_STOPPED  = 3'd1,
        ST_RANGE    = 3'd2,
        ST_BEFORE   = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_BAD_IDX  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_RBIN,
        ADDR_QUOT
    } t_addr_sel;

    typedef enum logic [1:0] {
        VAL_ZERO,
        VAL_RDATA,
        VAL_SUM
    } t_val_sel;

    typedef struct packed {
        logic      load;
        logic      clr_wr;
        logic      rd_en;
        t_addr_sel addr_sel;
        logic      set_start;
        logic      set_stop;
        logic      div_start;
        logic      rmw_wr;
        logic      out_load;
        t_val_sel  val_sel;
        t_status   status;
    } t_dp_cmd;

    typedef struct packed {
        logic item_cmd;
        logic rbin_ok;
        logic started;
        logic stopped;
        logic before_start;
        logic div_done;
        logic q_ge_nb;
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

// File: src/time_binned_byte_histogram_core.sv
// Top level of the time-binned byte histogram core.
// Reads and ignored records go straight to the output register; the first record takes a
// read-modify-write of bin 0, and a later record first passes the divider, then is added or stops.
// One item is in work at a time; the next is taken the cycle after the result is
// registered, later if the receiver still holds the previous result.
// Reset (synchronous, active low) starts a clearing pass over every entry of
// the bin memory; no item is accepted until it ends, config writes are taken.
`include "assert_macros.svh"

module time_binned_byte_histogram_core import tbbh_pkg::*; #(
    parameter int unsigned MAX_BINS     = MAX_BINS_DEF,
    parameter int unsigned BIN_WIDTH_US = BIN_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // timestamp_us[47:0], packet_bytes[63:48], read_bin[73:64], zero pad
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // cmd[0]
    input  logic                 i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // bin_value[47:0], total_bytes[95:48], is_stopped[96], zero pad
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // status[2:0]
    output logic [2:0]           o_m_axis_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd         w_cmd;
    t_dp_sts         w_sts;
    logic [TS_W-1:0] w_bin_value;
    logic [TS_W-1:0] w_total;
    logic            w_stopped;
    logic            w_has_value;
    logic            w_valued;
    logic            w_unvalued;
    logic            w_range_res;

    assign o_cfg_ready = 1'b1;

    tbbh_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_cmd     (w_cmd),
        .i_sts     (w_sts)
    );

    tbbh_dp #(
        .MAX_BINS     (MAX_BINS),
        .BIN_WIDTH_US (BIN_WIDTH_US)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_item_cmd  (i_s_axis_tuser),
        .i_ts        (i_s_axis_tdata[TS_W-1:0]),
        .i_bytes     (i_s_axis_tdata[TS_W +: BYTES_W]),
        .i_rbin      (i_s_axis_tdata[TS_W + BYTES_W +: RBIN_W]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_bin_value (w_bin_value),
        .o_total     (w_total),
        .o_status    (o_m_axis_tuser),
        .o_stopped   (w_stopped)
    );

    assign o_m_axis_tdata = {(M_TDATA_W - 2 * TS_W - 1)'(0), w_stopped, w_total, w_bin_value};

    assign w_has_value = (o_m_axis_tuser == ST_ADDED) || (o_m_axis_tuser == ST_READ_OK);
    assign w_valued    = o_m_axis_tvalid && w_has_value;
    assign w_unvalued  = o_m_axis_tvalid && !w_has_value;
    assign w_range_res = o_m_axis_tvalid && (o_m_axis_tuser == ST_RANGE);

    `ASSERT_ALWAYS(a_stop_sticky, i_clk, i_rst_n, !$fell(w_sts.stopped), "stop flag cleared")
    `ASSERT_IMPLIES(a_bin_le_total, i_clk, i_rst_n, w_valued, w_bin_value <= w_total, "bin > total")
    `ASSERT_IMPLIES(a_zero_value, i_clk, i_rst_n, w_unvalued, w_bin_value == '0, "nonzero value")
    `ASSERT_IMPLIES(a_range_stops, i_clk, i_rst_n, w_range_res, w_stopped, "range without stop")

endmodule

// File: src/tbbh_div.sv
// Division by the constant bin width through reciprocal multiplication
module tbbh_div import tbbh_pkg::*; #(
    parameter int unsigned MAX_BINS     = MAX_BINS_DEF,
    parameter int unsigned BIN_WIDTH_US = BIN_WIDTH_DEF,
    parameter int          NB_W         = CFG_W
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [TS_W-1:0] i_dividend,
    input  logic [NB_W-1:0] i_nb,
    output logic            o_done,
    output logic            o_over,
    output logic [TS_W-1:0] o_quot
);

    // any dividend below MAX_BINS bin widths fits in X_W bits
    localparam longint unsigned X_MAX = 64'(MAX_BINS) * 64'(BIN_WIDTH_US);
    localparam int X_W   = ($clog2(X_MAX) > 2) ? $clog2(X_MAX) : 2;
    localparam int L_W   = $clog2(BIN_WIDTH_US);
    localparam int SHIFT = X_W + L_W;
    localparam int M_W   = X_W + 1;
    localparam int LO_W  = (X_W + 1) / 2;
    localparam int HI_W  = X_W - LO_W;
    localparam int SUM_W = X_W + M_W + 1;
    localparam int DW    = $clog2(BIN_WIDTH_US + 1);
    localparam int LIM_W = NB_W + DW;
    localparam int CMP_W = (LIM_W > TS_W) ? LIM_W : TS_W;

    localparam logic [127:0] RECIP_WIDE =
        ((128'd1 << SHIFT) + 128'(BIN_WIDTH_US) - 128'd1) / 128'(BIN_WIDTH_US);
    localparam logic [M_W-1:0] RECIP   = M_W'(RECIP_WIDE);
    localparam logic [DW-1:0]  DIVISOR = DW'(BIN_WIDTH_US);

    logic [TS_W-1:0]       r_x;
    logic [LIM_W-1:0]      r_lim;
    logic [1:0]            r_cnt;
    logic                  r_busy;
    logic                  r_over;
    logic [LO_W+M_W-1:0]   r_plo;
    logic [HI_W+M_W-1:0]   r_phi;
    logic [TS_W-1:0]       r_quot;

    logic [SUM_W-1:0]      w_sum;

    assign w_sum = (SUM_W'(r_phi) << LO_W) + SUM_W'(r_plo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 2'd3;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // compare against the limit and form the low half of the product, then the high half, then scale down
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_dividend;
            r_lim <= LIM_W'(i_nb) * LIM_W'(DIVISOR);
        end else if (r_busy) begin
            if (r_cnt == 2'd3) begin
                r_over <= (CMP_W'(r_x) >= CMP_W'(r_lim));
                r_plo  <= (LO_W + M_W)'(r_x[LO_W-1:0]) * (LO_W + M_W)'(RECIP);
            end
            if (r_cnt == 2'd2) begin
                r_phi <= (HI_W + M_W)'(r_x[X_W-1:LO_W]) * (HI_W + M_W)'(RECIP);
            end
            if (r_cnt == 2'd1) begin
                r_quot <= TS_W'(w_sum >> SHIFT);
            end
        end
    end

    // the quotient holds only when the dividend is below the limit
    assign o_done = r_busy && (r_cnt == '0);
    assign o_over = r_over;
    assign o_quot = r_quot;

endmodule

// File: src/tbbh_dp.sv
// Datapath: item registers, bin memory, totals, divider and output register
module tbbh_dp import tbbh_pkg::*; #(
    parameter int unsigned MAX_BINS     = MAX_BINS_DEF,
    parameter int unsigned BIN_WIDTH_US = BIN_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_item_cmd,
    input  logic [TS_W-1:0]    i_ts,
    input  logic [BYTES_W-1:0] i_bytes,
    input  logic [RBIN_W-1:0]  i_rbin,
    input  logic               i_cfg_valid,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [TS_W-1:0]    o_bin_value,
    output logic [TS_W-1:0]    o_total,
    output logic [2:0]         o_status,
    output logic               o_stopped
);

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int MB_W  = $clog2(MAX_BINS + 1);
    localparam int NB_W  = (MB_W > CFG_W) ? MB_W : CFG_W;

    function automatic logic [TS_W-1:0] sat_add(input logic [TS_W-1:0] a,
                                                 input logic [BYTES_W-1:0] b);
        logic [TS_W:0] s;
        s = {1'b0, a} + (TS_W + 1)'(b);
        return s[TS_W] ? '1 : s[TS_W-1:0];
    endfunction

    logic [CFG_W-1:0]   r_num_bins;
    logic               r_item_cmd;
    logic [TS_W-1:0]    r_ts;
    logic [BYTES_W-1:0] r_bytes;
    logic [RBIN_W-1:0]  r_rbin;
    logic               r_started;
    logic               r_stopped;
    logic [TS_W-1:0]    r_start;
    logic [TS_W-1:0]    r_total;
    logic [TS_W-1:0]    r_sum;
    logic [IDX_W-1:0]   r_clr;
    logic [IDX_W-1:0]   r_addr;
    logic [TS_W-1:0]    r_rdata;
    logic [TS_W-1:0]    r_bins [MAX_BINS];

    logic               r_out_valid;
    logic [TS_W-1:0]    r_out_value;
    logic [TS_W-1:0]    r_out_total;
    logic [2:0]         r_out_status;
    logic               r_out_stopped;

    logic [NB_W-1:0]    w_nb;
    logic [NB_W-1:0]    w_cfg_ext;
    logic [TS_W-1:0]    w_nb_ext;
    logic [TS_W-1:0]    w_rbin_ext;
    logic [TS_W-1:0]    w_quot;
    logic               w_div_done;
    logic               w_div_over;
    logic [IDX_W-1:0]   w_rd_addr;
    logic [TS_W-1:0]    w_new_sum;
    logic [TS_W-1:0]    w_out_value;

    // effective bin count: zero acts as one, clamp to the store depth
    assign w_cfg_ext = NB_W'(r_num_bins);
    always_comb begin
        if (r_num_bins == '0) begin
            w_nb = NB_W'(1);
        end else if (w_cfg_ext > NB_W'(MAX_BINS)) begin
            w_nb = NB_W'(MAX_BINS);
        end else begin
            w_nb = w_cfg_ext;
        end
    end

    assign w_nb_ext   = TS_W'(w_nb);
    assign w_rbin_ext = TS_W'(r_rbin);

    tbbh_div #(
        .MAX_BINS     (MAX_BINS),
        .BIN_WIDTH_US (BIN_WIDTH_US),
        .NB_W         (NB_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_ts - r_start),
        .i_nb       (w_nb),
        .o_done     (w_div_done),
        .o_over     (w_div_over),
        .o_quot     (w_quot)
    );

    always_comb begin
        unique case (i_cmd.addr_sel)
            ADDR_RBIN: w_rd_addr = w_rbin_ext[IDX_W-1:0];
            ADDR_QUOT: w_rd_addr = w_quot[IDX_W-1:0];
            default:   w_rd_addr = '0;
        endcase
    end

    assign w_new_sum = sat_add(r_rdata, r_bytes);

    always_comb begin
        unique case (i_cmd.val_sel)
            VAL_RDATA: w_out_value = r_rdata;
            VAL_SUM:   w_out_value = r_sum;
            default:   w_out_value = '0;
        endcase
    end

    // bin store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_bins[r_clr] <= '0;
        end else if (i_cmd.rmw_wr) begin
            r_bins[r_addr] <= w_new_sum;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_bins[w_rd_addr];
            r_addr  <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bins  <= NUM_BINS_RST;
            r_started   <= 1'b0;
            r_stopped   <= 1'b0;
            r_start     <= '0;
            r_total     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_num_bins <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.set_start) begin
                r_started <= 1'b1;
                r_start   <= r_ts;
            end
            if (i_cmd.set_stop) begin
                r_stopped <= 1'b1;
            end
            if (i_cmd.rmw_wr) begin
                r_total <= sat_add(r_total, r_bytes);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item_cmd <= i_item_cmd;
            r_ts       <= i_ts;
            r_bytes    <= i_bytes;
            r_rbin     <= i_rbin;
        end
        if (i_cmd.rmw_wr) begin
            r_sum <= w_new_sum;
        end
        if (i_cmd.out_load) begin
            r_out_value   <= w_out_value;
            r_out_total   <= r_total;
            r_out_status  <= i_cmd.status;
            r_out_stopped <= r_stopped;
        end
    end

    always_comb begin
        o_sts.item_cmd     = r_item_cmd;
        o_sts.rbin_ok      = (w_rbin_ext < w_nb_ext);
        o_sts.started      = r_started;
        o_sts.stopped      = r_stopped;
        o_sts.before_start = (r_ts < r_start);
        o_sts.div_done     = w_div_done;
        o_sts.q_ge_nb      = w_div_over;
        o_sts.clr_last     = (r_clr == IDX_W'(MAX_BINS - 1));
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_bin_value = r_out_value;
    assign o_total     = r_out_total;
    assign o_status    = r_out_status;
    assign o_stopped   = r_out_stopped;

endmodule

// File: src/tbbh_ctrl.sv
// Controller: clearing pass and per-item sequencing of the datapath
module tbbh_ctrl import tbbh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_CHECK,
        S_ADD,
        S_FIN
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_status  r_status;
    t_status  n_status;
    t_val_sel r_vsel;
    t_val_sel n_vsel;

    always_comb begin
        n_state        = r_state;
        n_status       = r_status;
        n_vsel         = r_vsel;
        o_cmd          = '0;
        o_cmd.status   = r_status;
        o_cmd.val_sel  = r_vsel;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (i_sts.item_cmd == CMD_READ) begin
                    if (i_sts.rbin_ok) begin
                        o_cmd.rd_en    = 1'b1;
                        o_cmd.addr_sel = ADDR_RBIN;
                        n_status       = ST_READ_OK;
                        n_vsel         = VAL_RDATA;
                    end else begin
                        n_status = ST_BAD_IDX;
                        n_vsel   = VAL_ZERO;
                    end
                    n_state = S_FIN;
                end else if (i_sts.stopped) begin
                    n_status = ST_STOPPED;
                    n_vsel   = VAL_ZERO;
                    n_state  = S_FIN;
                end else if (!i_sts.started) begin
                    // first record fixes the start time and lands in bin 0
                    o_cmd.set_start = 1'b1;
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.addr_sel  = ADDR_ZERO;
                    n_status        = ST_ADDED;
                    n_vsel          = VAL_SUM;
                    n_state         = S_ADD;
                end else if (i_sts.before_start) begin
                    n_status = ST_BEFORE;
                    n_vsel   = VAL_ZERO;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.q_ge_nb) begin
                    o_cmd.set_stop = 1'b1;
                    n_status       = ST_RANGE;
                    n_vsel         = VAL_ZERO;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_sel = ADDR_QUOT;
                    n_status       = ST_ADDED;
                    n_vsel         = VAL_SUM;
                    n_state        = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.rmw_wr = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_status <= ST_ADDED;
            r_vsel   <= VAL_ZERO;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_vsel   <= n_vsel;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);

endmodule

// File: test/time_binned_byte_histogram_core_test.sv
// Self-checking testbench for the time-binned byte histogram core
`timescale 1ns / 100ps

module time_binned_byte_histogram_core_test;
    import tbbh_pkg::*;

    localparam logic [47:0] START_TS     = 48'h4000_0000_0000;
    localparam logic [47:0] BIN_US       = 48'(BIN_WIDTH_DEF);
    localparam int          N_PHASES     = 7;
    localparam int          PHASE_ITEMS  = 264;
    localparam int          STOP_AT      = 200;
    localparam int          HOLD_AT      = 3000;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          SETTLE       = 64;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          N_DIRECTED   = 17;

    typedef struct packed {
        logic [47:0] bin_value;
        logic [47:0] total;
        t_status     status;
        logic        stopped;
    } hist_result_t;

    typedef struct packed {
        logic         cmd;
        logic [47:0]  ts;
        logic [15:0]  nbytes;
        logic [9:0]   rbin;
        logic         typed;
        hist_result_t want;
    } stim_row_t;

    localparam hist_result_t NO_RES = '{48'd0, 48'd0, ST_ADDED, 1'b0};

    // Reads after reset, the first record, extremes of bytes and bins, edges of bins.
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{CMD_READ,   48'd0, 16'd0, 10'd0, 1'b1, '{48'd0, 48'd0, ST_READ_OK, 1'b0}},
        '{CMD_READ,   48'd0, 16'd0, 10'd1023, 1'b1, '{48'd0, 48'd0, ST_READ_OK, 1'b0}},
        '{CMD_RECORD, START_TS, 16'hFFFF, 10'd0, 1'b1,
          '{48'd65535, 48'd65535, ST_ADDED, 1'b0}},
        '{CMD_RECORD, 48'd0, 16'd100, 10'd0, 1'b1, '{48'd0, 48'd65535, ST_BEFORE, 1'b0}},
        '{CMD_RECORD, START_TS - 48'd1, 16'h5555, 10'd0, 1'b0, NO_RES},
        '{CMD_RECORD, START_TS + 48'd999999, 16'h0000, 10'd0, 1'b0, NO_RES},
        '{CMD_RECORD, START_TS + BIN_US, 16'h0001, 10'd0, 1'b0, NO_RES},
        '{CMD_RECORD, START_TS + 48'd1023 * BIN_US + 48'd999999, 16'hFFFF, 10'd0,
          1'b0, NO_RES},
        '{CMD_RECORD, START_TS + 48'd512 * BIN_US, 16'hAAAA, 10'd0, 1'b0, NO_RES},
        '{CMD_READ,   48'd0, 16'd0, 10'd1023, 1'b0, NO_RES},
        '{CMD_READ,   48'd0, 16'd0, 10'd1, 1'b0, NO_RES},
        '{CMD_READ,   48'd0, 16'd0, 10'd512, 1'b0, NO_RES},
        '{CMD_READ,   48'd0, 16'd0, 10'd0, 1'b0, NO_RES},
        '{CMD_RECORD, START_TS + 48'd3 * BIN_US + 48'd12345, 16'h8000, 10'd0,
          1'b0, NO_RES},
        '{CMD_READ,   48'd0, 16'd0, 10'd3, 1'b0, NO_RES},
        '{CMD_RECORD, START_TS + 48'd1023 * BIN_US, 16'h7FFF, 10'd0, 1'b0, NO_RES},
        '{CMD_READ,   48'd0, 16'd0, 10'd1023, 1'b0, NO_RES}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = CMD_RECORD;
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_W-1:0]     cfg_data = '0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire [M_TDATA_W-1:0]  m_tdata;
    wire [2:0]            m_tuser;
    wire                  cfg_ready;

    // Histogram state as the testbench sees it
    logic [CFG_W-1:0] bin_count = NUM_BINS_RST;
    logic             acc_started = 1'b0;
    logic             acc_stopped = 1'b0;
    logic [47:0]      start_ts = '0;
    logic [47:0]      bin_sums [MAX_BINS_DEF];
    logic [47:0]      byte_total = '0;

    hist_result_t hist_expect_q [$];
    int           fail_count = 0;
    int           cycle_count = 0;
    int           burst_left = 0;

    time_binned_byte_histogram_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic int unsigned bins_in_use();
        if (bin_count == 0) return 1;
        if (bin_count > MAX_BINS_DEF) return MAX_BINS_DEF;
        return int'(bin_count);
    endfunction

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    // Advance the histogram state by one item and return the result it causes
    function automatic hist_result_t predict_histogram(input logic cmd, input logic [47:0] ts,
                                                       input logic [15:0] nbytes,
                                                       input logic [9:0] rbin);
        hist_result_t r;
        logic [47:0]  idx;
        int unsigned  nb;
        nb = bins_in_use();
        r.bin_value = '0;
        r.status = ST_ADDED;
        if (cmd == CMD_READ) begin
            if (int'(rbin) < nb) begin
                r.bin_value = bin_sums[rbin];
                r.status = ST_READ_OK;
            end else begin
                r.status = ST_BAD_IDX;
            end
        end else if (acc_stopped) begin
            r.status = ST_STOPPED;
        end else if (!acc_started) begin
            acc_started = 1'b1;
            start_ts = ts;
            bin_sums[0] = sat_add48(bin_sums[0], 48'(nbytes));
            byte_total = sat_add48(byte_total, 48'(nbytes));
            r.bin_value = bin_sums[0];
        end else if (ts < start_ts) begin
            r.status = ST_BEFORE;
        end else begin
            idx = (ts - start_ts) / BIN_US;
            if (idx >= 48'(nb)) begin
                acc_stopped = 1'b1;
                r.status = ST_RANGE;
            end else begin
                bin_sums[idx] = sat_add48(bin_sums[idx], 48'(nbytes));
                byte_total = sat_add48(byte_total, 48'(nbytes));
                r.bin_value = bin_sums[idx];
            end
        end
        r.total = byte_total;
        r.stopped = acc_stopped;
        return r;
    endfunction

    // Offer one item in bursts with random gaps; predict at acceptance
    task automatic push_item(input logic cmd, input logic [47:0] ts, input logic [15:0] nbytes,
                             input logic [9:0] rbin, input logic typed,
                             input hist_result_t typed_want);
        int           gap;
        hist_result_t want;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'({rbin, nbytes, ts});
        s_tuser <= cmd;
        do @(posedge clk); while (!s_tready);
        want = predict_histogram(cmd, ts, nbytes, rbin);
        if (typed) want = typed_want;
        hist_expect_q.push_back(want);
    endtask

    task automatic push_random_item();
        int unsigned nb;
        int unsigned pick;
        logic [47:0] ts;
        logic [15:0] nbytes;
        logic [9:0]  rbin;
        nb = bins_in_use();
        pick = $urandom_range(0, 99);
        nbytes = 16'($urandom);
        rbin = 10'($urandom);
        ts = start_ts + 48'($urandom_range(0, nb - 1)) * BIN_US
             + 48'($urandom_range(0, 999999));
        if (pick < 50) begin
            push_item(CMD_RECORD, ts, nbytes, rbin, 1'b0, NO_RES);
        end else if (pick < 58) begin
            // hit the first or last microsecond of a bin
            if ($urandom_range(0, 1) == 1)
                ts = start_ts + 48'(nb) * BIN_US - 48'd1;
            else
                ts = start_ts + 48'($urandom_range(0, nb - 1)) * BIN_US;
            push_item(CMD_RECORD, ts, nbytes, rbin, 1'b0, NO_RES);
        end else if (pick < 70) begin
            // early records; any time at all once accumulation has stopped
            ts = {16'($urandom), 32'($urandom)};
            if (!acc_stopped) ts = ts % start_ts;
            push_item(CMD_RECORD, ts, nbytes, rbin, 1'b0, NO_RES);
        end else begin
            if ($urandom_range(0, 1) == 1) rbin = 10'($urandom_range(0, nb - 1));
            push_item(CMD_READ, 48'($urandom) << $urandom_range(0, 16), nbytes, rbin,
                      1'b0, NO_RES);
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (hist_expect_q.size() != 0);
    endtask

    task automatic write_bin_count(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        bin_count = value;
    endtask

    // Sender and phase sequencing
    initial begin : stimulus
        logic [CFG_W-1:0] phase_cfg [N_PHASES];
        phase_cfg = '{11'd0, 11'd2047, 11'd1, 11'd7, 11'd512, 11'd1024, 11'd40};
        phase_cfg[4] = CFG_W'($urandom_range(2, 1023));
        for (int i = 0; i < MAX_BINS_DEF; i++) bin_sums[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            push_item(DIRECTED[i].cmd, DIRECTED[i].ts, DIRECTED[i].nbytes, DIRECTED[i].rbin,
                      DIRECTED[i].typed, DIRECTED[i].want);
        end
        for (int p = 0; p < N_PHASES; p++) begin
            wait_results_drained();
            write_bin_count(phase_cfg[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == N_PHASES - 1 && k == STOP_AT)
                    // first bin past the end: stop for good
                    push_item(CMD_RECORD, start_ts + 48'(bins_in_use()) * BIN_US
                              + 48'($urandom_range(0, 999999)), 16'($urandom), 10'd0,
                              1'b0, NO_RES);
                else if (p == N_PHASES - 1 && k == STOP_AT + 1)
                    push_item(CMD_RECORD, '1, 16'hFFFF, 10'h3FF, 1'b0, NO_RES);
                else
                    push_random_item();
            end
        end
        wait_results_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver: segments of steady, random and sparse ready, plus one long hold
    initial begin : drain_side
        int rx_cycle;
        int seg_left;
        int mode;
        int hold_left;
        rx_cycle = 0;
        seg_left = 0;
        mode = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle == HOLD_AT) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(5, 200);
                    mode = $urandom_range(0, 2);
                end
                seg_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin : result_check
        hist_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (hist_expect_q.size() == 0) begin
                $error("result with no item waiting: tdata %h tuser %0d", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = hist_expect_q.pop_front();
                if (m_tdata[47:0] !== want.bin_value) begin
                    $error("bin_value: expected %0d, got %0d", want.bin_value, m_tdata[47:0]);
                    fail_count++;
                end
                if (m_tdata[95:48] !== want.total) begin
                    $error("total_bytes: expected %0d, got %0d", want.total, m_tdata[95:48]);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[96] !== want.stopped) begin
                    $error("is_stopped: expected %0d, got %0d", want.stopped, m_tdata[96]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
